@@ hw/rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Depends on nothing; imported by every module of the block but dq_ram.
`default_nettype none

package dq_pkg;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_READ_AT    = 3'd4,
		ACT_WRITE_AT   = 3'd5
	} dq_act_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   data_in;
	} dq_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0]  data_out;
		logic               data_valid;
		logic [COUNT_W-1:0] entry_count;
		logic               overflow;
	} dq_result_t;

	// Memory control decided when a command beat is taken.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic data_valid;
		logic write_back;
		logic overflow;
	} dq_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue: ring pointers, command stage, RAM.
// Depends on dq_pkg, dq_decode and dq_ram.
//
// One command beat is taken at a rising edge with start high and busy low. That edge
// updates the head slot and the entry count and issues the single RAM access the
// command needs: a write for a push, a read for a pop, read or write-at. The RAM
// returns read data from a registered port, so the result beat follows in the next
// cycle, marked by done for exactly one cycle; the receiver cannot stall it and must
// take it then. Busy is high during that result cycle, so the block takes no new
// command until the result beat is out; this is set by the registered read of the
// RAM and by the write-back of write-at, which replaces the word it has just
// read in the same result cycle. The entry count on the result is the count after
// the command. Entries that were never written are never read, so the store needs
// no clearing after reset and the block takes commands from the first cycle.
`default_nettype none

module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dq_cmd_t    cmd,
	output logic            busy,
	output logic            done,
	output dq_result_t      result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// ring state
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;

	// command in flight, registered when it was taken
	logic                 valid_s1;
	dq_ctl_t              ctl_s1;
	logic [AW-1:0]        slot_s1;
	logic [WORD_BITS-1:0] word_s1;

	logic                 accept;
	dq_ctl_t              ctl;
	logic [AW-1:0]        slot;
	logic [AW-1:0]        new_head;
	logic [CW-1:0]        new_count;
	logic [WORD_BITS-1:0] word;
	logic                 wb_en;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [WORD_BITS-1:0] ram_rd_data;

	assign busy   = valid_s1;
	assign accept = start && !busy;

	// keep only the low WORD_BITS bits of the incoming word
	assign word = WORD_BITS'(cmd.data_in);

	dq_decode #(
		.DEPTH(DEPTH)
	) u_decode (
		.cmd       (cmd),
		.head      (head_q),
		.count     (count_q),
		.ctl       (ctl),
		.slot      (slot),
		.new_head  (new_head),
		.new_count (new_count)
	);

	// advance ring pointers on every taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			head_q   <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				head_q  <= new_head;
				count_q <= new_count;
			end
		end
	end

	// hold the command's slot, word and flags for the result cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl;
			slot_s1 <= slot;
			word_s1 <= word;
		end
	end

	// write-at replaces the entry it read, in the result cycle; no beat is
	// taken then, so the write port is never claimed twice
	assign wb_en       = valid_s1 && ctl_s1.write_back;
	assign ram_wr_en   = (accept && ctl.wr_en) || wb_en;
	assign ram_wr_addr = wb_en ? slot_s1 : slot;
	assign ram_wr_data = wb_en ? word_s1 : word;
	assign ram_rd_en   = accept && ctl.rd_en;

	dq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (slot),
		.rd_data (ram_rd_data)
	);

	// result beat: drop the read data when the command returned no entry
	assign done               = valid_s1;
	assign result.data_out    = ctl_s1.data_valid ? DATA_W'(ram_rd_data) : '0;
	assign result.data_valid  = ctl_s1.data_valid;
	assign result.entry_count = COUNT_W'(count_q);
	assign result.overflow    = ctl_s1.overflow;

endmodule

`default_nettype wire

@@ hw/rtl/dq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dq_decode.sv @@
// Command decode and ring pointer arithmetic for the double-ended queue.
// Depends on dq_pkg.
`default_nettype none

module dq_decode
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire dq_cmd_t                       cmd,
	input  wire logic [$clog2(DEPTH)-1:0]      head,
	input  wire logic [$clog2(DEPTH+1)-1:0]    count,
	output dq_ctl_t                            ctl,
	output logic      [$clog2(DEPTH)-1:0]      slot,
	output logic      [$clog2(DEPTH)-1:0]      new_head,
	output logic      [$clog2(DEPTH+1)-1:0]    new_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int LW = (CW > POS_W) ? CW : POS_W;

	logic [LW-1:0]       pos_l;
	logic [LW-1:0]       cnt_l;
	logic                full;
	logic                empty;
	logic                in_range;
	logic [ACTION_W-1:0] eff_act;
	logic [CW-1:0]       offset;
	logic [SW-1:0]       sum;
	logic [AW-1:0]       ring_slot;

	assign pos_l    = LW'(cmd.position);
	assign cnt_l    = LW'(count);
	assign full     = (count == CW'(DEPTH));
	assign empty    = (count == '0);
	assign in_range = (pos_l < cnt_l);

	// a write at the count behaves as a push at the back
	assign eff_act = (cmd.action == ACT_WRITE_AT && pos_l == cnt_l) ? ACT_PUSH_BACK
	                                                                : cmd.action;

	// one adder with a single wrap step: head plus an offset, below DEPTH whenever the slot is used
	always_comb begin
		case (eff_act)
			ACT_PUSH_FRONT: offset = CW'(DEPTH - 1);
			ACT_PUSH_BACK:  offset = count;
			ACT_POP_FRONT:  offset = CW'(1);
			ACT_POP_BACK:   offset = count - CW'(1);
			default:        offset = CW'(cmd.position);
		endcase
	end

	assign sum       = SW'(head) + SW'(offset);
	assign ring_slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);

	always_comb begin
		ctl       = '0;
		slot      = ring_slot;
		new_head  = head;
		new_count = count;
		unique case (eff_act)
			ACT_PUSH_FRONT: begin
				if (full) begin
					ctl.overflow = 1'b1;
				end else begin
					ctl.wr_en = 1'b1;
					new_head  = ring_slot;
					new_count = count + CW'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					ctl.overflow = 1'b1;
				end else begin
					ctl.wr_en = 1'b1;
					new_count = count + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				slot = head;
				if (!empty) begin
					ctl.rd_en      = 1'b1;
					ctl.data_valid = 1'b1;
					new_head       = ring_slot;
					new_count      = count - CW'(1);
				end
			end
			ACT_POP_BACK: begin
				if (!empty) begin
					ctl.rd_en      = 1'b1;
					ctl.data_valid = 1'b1;
					new_count      = count - CW'(1);
				end
			end
			ACT_READ_AT: begin
				if (in_range) begin
					ctl.rd_en      = 1'b1;
					ctl.data_valid = 1'b1;
				end
			end
			ACT_WRITE_AT: begin
				if (in_range) begin
					ctl.rd_en      = 1'b1;
					ctl.data_valid = 1'b1;
					ctl.write_back = 1'b1;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/dq_checker.sv @@
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on dq_pkg and double_ended_queue.
`default_nettype none

module dq_checker
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire dq_result_t result
);

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken command beat gave no result beat");

	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without a taken command beat");

	a_valid_not_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.data_valid && result.overflow))
		else $error("result both valid and overflowed");

	a_ovf_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |-> (result.entry_count == COUNT_W'(DEPTH)))
		else $error("overflow while not full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.data_valid) |-> (result.data_out == '0))
		else $error("nonzero word on a result without an entry");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

`default_nettype wire

@@ tb/sv/double_ended_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for double_ended_queue: directed corner cases on an empty and a full store,
// then a long biased random mix of actions, each result checked against a local deque model.
// Depends on dq_pkg and the double_ended_queue RTL only.

module double_ended_queue_tb;
	import dq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int WORD_BITS      = 32;
	localparam int SLOT_W         = $clog2(DEPTH);
	localparam int HALF_CYCLE     = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ACTIONS = 700;
	localparam int MAX_GAP        = 8;
	localparam int MAX_BURST      = 12;
	// The longest stretch without a beat in a correct run is set by MAX_GAP; allow far more.
	localparam int IDLE_LIMIT     = 100;
	// Result follows its command in the next cycle; then watch on for stray strobes.
	localparam int DRAIN_CYCLES   = 4;
	localparam logic [POS_W-1:0] MAX_POSITION = '1;

	// Action codes the block does not define; it must leave its state alone on these.
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

	// Bias of a random phase: drive the fill level up, keep it level, or drain it.
	typedef enum int {
		LEAN_GROW,
		LEAN_EVEN,
		LEAN_SHRINK
	} lean_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	dq_cmd_t    cmd;
	logic       busy;
	logic       done;
	dq_result_t result;

	// Deque model: ring of words, slot of the front entry, and number of entries held.
	logic [DATA_W-1:0]  ring_words [DEPTH];
	logic [SLOT_W-1:0]  front_slot = '0;
	logic [COUNT_W-1:0] live_count = '0;
	// Fill level as of the previous edge, for aiming positions; updated without races.
	logic [COUNT_W-1:0] count_seen = '0;

	dq_result_t awaited_results [$];

	int mismatches      = 0;
	int results_checked = 0;
	int beats_taken     = 0;
	int spare_beats     = 0;
	int dropped_pushes  = 0;
	int words_returned  = 0;
	int idle_cycles     = 0;
	int burst_left      = 0;
	bit steady          = 1'b0;

	double_ended_queue #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #HALF_CYCLE clk = ~clk;

	// Apply one action to the deque model and return the result it must produce.
	function automatic dq_result_t deque_step(input dq_cmd_t c);
		logic [ACTION_W-1:0] act;
		logic [SLOT_W-1:0]   slot;
		dq_result_t          r;
		r   = '0;
		act = c.action;
		// A write right behind the last entry appends, exactly like a push at the back.
		if (act == ACT_WRITE_AT && c.position == live_count)
			act = ACT_PUSH_BACK;
		case (act)
			ACT_PUSH_FRONT: begin
				if (live_count == COUNT_W'(DEPTH)) begin
					r.overflow = 1'b1;
				end else begin
					front_slot             = front_slot - SLOT_W'(1);
					ring_words[front_slot] = c.data_in;
					live_count             = live_count + COUNT_W'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (live_count == COUNT_W'(DEPTH)) begin
					r.overflow = 1'b1;
				end else begin
					slot             = front_slot + live_count[SLOT_W-1:0];
					ring_words[slot] = c.data_in;
					live_count       = live_count + COUNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (live_count != '0) begin
					r.data_out   = ring_words[front_slot];
					r.data_valid = 1'b1;
					front_slot   = front_slot + SLOT_W'(1);
					live_count   = live_count - COUNT_W'(1);
				end
			end
			ACT_POP_BACK: begin
				if (live_count != '0) begin
					slot         = front_slot + SLOT_W'(live_count - COUNT_W'(1));
					r.data_out   = ring_words[slot];
					r.data_valid = 1'b1;
					live_count   = live_count - COUNT_W'(1);
				end
			end
			ACT_READ_AT: begin
				if (c.position < live_count) begin
					slot         = front_slot + c.position[SLOT_W-1:0];
					r.data_out   = ring_words[slot];
					r.data_valid = 1'b1;
				end
			end
			ACT_WRITE_AT: begin
				// Return the word being replaced.
				if (c.position < live_count) begin
					slot             = front_slot + c.position[SLOT_W-1:0];
					r.data_out       = ring_words[slot];
					r.data_valid     = 1'b1;
					ring_words[slot] = c.data_in;
				end
			end
			default: ;
		endcase
		r.entry_count = live_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Single monitor for both directions, so ordering within an edge cannot matter:
	// check the result beat first, then log the command beat taken at the same edge.
	always @(posedge clk) begin : beat_monitor
		dq_result_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $time, result);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("data_out", want.data_out, result.data_out);
					check_field("data_valid", DATA_W'(want.data_valid),
						DATA_W'(result.data_valid));
					check_field("entry_count", DATA_W'(want.entry_count),
						DATA_W'(result.entry_count));
					check_field("overflow", DATA_W'(want.overflow),
						DATA_W'(result.overflow));
					results_checked++;
					if (want.overflow)
						dropped_pushes++;
					if (want.data_valid)
						words_returned++;
				end
			end
			if (start && !busy) begin
				awaited_results.push_back(deque_step(cmd));
				beats_taken++;
				if (cmd.action == ACT_SPARE_A || cmd.action == ACT_SPARE_B)
					spare_beats++;
			end
			count_seen <= live_count;
			// Watchdog: count cycles in which no beat moves in either direction.
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic dq_cmd_t make_cmd(input logic [ACTION_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] word);
		dq_cmd_t c;
		c.action   = act;
		c.position = pos;
		c.data_in  = word;
		return c;
	endfunction

	// Sender pacing: bursts of random length separated by random gaps; steady phases skip gaps.
	task automatic take_pause();
		int          gap;
		logic [63:0] noise;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, MAX_BURST);
		gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
		repeat (gap) begin
			// Drop start and scramble the bus; the block must ignore it.
			noise = {$urandom(), $urandom()};
			start <= 1'b0;
			cmd   <= noise[$bits(dq_cmd_t)-1:0];
			@(posedge clk);
		end
	endtask

	// Present one command beat and hold it until the block takes it.
	task automatic send_action(input dq_cmd_t c);
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		take_pause();
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Aim mostly inside the held entries, sometimes right at the end, sometimes anywhere.
	function automatic logic [POS_W-1:0] random_position();
		int roll;
		roll = $urandom_range(9);
		if (roll < 7 && count_seen != '0)
			return POS_W'($urandom_range(count_seen - COUNT_W'(1)));
		else if (roll < 8)
			return count_seen;
		return POS_W'($urandom_range(MAX_POSITION));
	endfunction

	function automatic dq_cmd_t random_action(input lean_t lean);
		dq_cmd_t c;
		int      roll;
		int      push_w;
		int      pop_w;
		push_w = (lean == LEAN_GROW) ? 32 : (lean == LEAN_SHRINK) ? 10 : 20;
		pop_w  = (lean == LEAN_GROW) ? 10 : (lean == LEAN_SHRINK) ? 32 : 20;
		roll   = $urandom_range(99);
		if (roll < 2)
			c.action = (roll == 0) ? ACT_SPARE_A : ACT_SPARE_B;
		else if (roll < 2 + push_w)
			c.action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
		else if (roll < 2 + push_w + pop_w)
			c.action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
		else
			c.action = $urandom_range(1) ? ACT_READ_AT : ACT_WRITE_AT;
		c.position = random_position();
		c.data_in  = random_word();
		return c;
	endfunction

	// Every pop, read and write on an empty store misses; unused codes leave everything alone.
	task automatic test_empty_deque();
		send_action(make_cmd(ACT_POP_FRONT, 0, '0));
		send_action(make_cmd(ACT_POP_BACK, MAX_POSITION, '1));
		send_action(make_cmd(ACT_READ_AT, 0, 32'h1234_5678));
		send_action(make_cmd(ACT_WRITE_AT, 1, 32'h8765_4321));
		send_action(make_cmd(ACT_SPARE_A, 0, '0));
		send_action(make_cmd(ACT_SPARE_B, MAX_POSITION, '1));
	endtask

	// Fill from both ends, hit every full-store case, then pull from both ends.
	task automatic test_full_deque();
		for (int i = 0; i < DEPTH - 1; i++)
			send_action(make_cmd(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, POS_W'(i),
				(i == 0) ? '0 : (i == 1) ? '1 : $urandom()));
		// Write right behind the last entry: appends the final word.
		send_action(make_cmd(ACT_WRITE_AT, POS_W'(DEPTH - 1), 32'hA5A5_5A5A));
		// Pushes into a full store: drop and flag.
		send_action(make_cmd(ACT_PUSH_FRONT, 0, 32'hDEAD_0001));
		send_action(make_cmd(ACT_PUSH_BACK, 0, 32'hDEAD_0002));
		send_action(make_cmd(ACT_WRITE_AT, POS_W'(DEPTH), 32'hDEAD_0003));
		// Peek both ends, then read past the end.
		send_action(make_cmd(ACT_READ_AT, 0, '0));
		send_action(make_cmd(ACT_READ_AT, POS_W'(DEPTH - 1), '0));
		send_action(make_cmd(ACT_READ_AT, POS_W'(DEPTH), '0));
		send_action(make_cmd(ACT_READ_AT, MAX_POSITION, '1));
		// Replace the last entry, and try a write far beyond the end.
		send_action(make_cmd(ACT_WRITE_AT, POS_W'(DEPTH - 1), '1));
		send_action(make_cmd(ACT_WRITE_AT, MAX_POSITION, 32'hDEAD_0004));
		send_action(make_cmd(ACT_POP_FRONT, 0, '0));
		send_action(make_cmd(ACT_POP_BACK, 0, '0));
	endtask

	// Phases that lean toward growth, balance and drain, so the ring wraps many times
	// and the fill level sweeps between empty and full.
	task automatic test_random_mix();
		int      counted;
		int      phase;
		lean_t   lean;
		dq_cmd_t c;
		counted = 0;
		phase   = 0;
		while (counted < RANDOM_ACTIONS) begin
			case (phase % 4)
				0: lean = LEAN_GROW;
				2: lean = LEAN_SHRINK;
				default: lean = LEAN_EVEN;
			endcase
			steady = ($urandom_range(3) == 0);
			repeat ($urandom_range(20, 60)) begin
				c = random_action(lean);
				send_action(c);
				if (c.action != ACT_SPARE_A && c.action != ACT_SPARE_B)
					counted++;
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin : run
		start  <= 1'b0;
		cmd    <= '0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_deque();
		test_full_deque();
		test_random_mix();

		// Release the bus, wait for every outstanding result, then watch for strays.
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d command beats (%0d with unused codes), %0d results checked.",
			beats_taken, spare_beats, results_checked);
		$display("Saw %0d pushes dropped on a full store and %0d words returned.",
			dropped_pushes, words_returned);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
